/* sv/tsqd_pkg.sv */
// Package for the thick segment quad block.
// Holds widths, item and register codes, the perpendicular result type and the clamp helper.
// It depends on nothing; the other files refer to it by scoped names.
package tsqd_pkg;

  localparam int CW   = 16;  // coordinate width, signed Q12.4
  localparam int DW   = CW + 1;  // endpoint difference width
  localparam int TW   = 12;  // wall thickness width
  localparam int AW   = 15;  // area bound width
  localparam int NW   = TW + DW;  // numerator t * |d|
  localparam int DSW  = 2 * DW + 1;  // dx^2 + dy^2
  localparam int NNW  = 2 * NW;  // numerator squared
  localparam int QB   = TW;  // quotient bits
  localparam int ACCW = NNW + 4;  // accumulator width of the root loop
  localparam int MW   = QB + 1;  // rounded magnitude width
  localparam int OW   = MW + 1;  // signed offset width
  localparam int RW   = 2;  // register index width

  localparam logic KIND_SET  = 1'b0;
  localparam logic KIND_DRAG = 1'b1;

  localparam logic [RW-1:0] CFG_THICK  = 2'd0;
  localparam logic [RW-1:0] CFG_AREA_W = 2'd1;
  localparam logic [RW-1:0] CFG_AREA_H = 2'd2;

  localparam logic [TW-1:0] THICK_RST  = 12'd160;
  localparam logic [AW-1:0] AREA_W_RST = 15'd12800;
  localparam logic [AW-1:0] AREA_H_RST = 15'd9600;

  typedef struct packed {
    logic signed [OW-1:0] ox;
    logic signed [OW-1:0] oy;
  } perp_t;

  function automatic logic signed [CW-1:0] sat_coord(input logic signed [CW:0] v);
    logic signed [CW-1:0] r;
    if (v[CW] != v[CW-1]) begin
      r = v[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

/* sv/tsqd_perp.sv */
// Perpendicular offset unit: one shared multiplier and one shift-add compare loop.
// Gives t * (-dy, dx) / length, rounded half up per component, or (0, t) for zero length.
// Depends on tsqd_pkg.
module tsqd_perp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [tsqd_pkg::DW-1:0] dx_i,
  input  logic signed [tsqd_pkg::DW-1:0] dy_i,
  input  logic [tsqd_pkg::TW-1:0]      thick_i,
  output logic                         done_o,
  output tsqd_pkg::perp_t              perp_o
);

  localparam logic [2:0] R_IDLE = 3'd0;
  localparam logic [2:0] R_MUL  = 3'd1;
  localparam logic [2:0] R_BIT  = 3'd2;
  localparam logic [2:0] R_RND  = 3'd3;
  localparam logic [2:0] R_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [3:0] bit_q, bit_d;
  logic       comp_q, comp_d;

  logic [tsqd_pkg::DW-1:0]   ax_q, ax_d, ay_q, ay_d;
  logic                      dy_pos_q, dy_pos_d, dx_neg_q, dx_neg_d;
  logic [tsqd_pkg::TW-1:0]   t_q, t_d;
  logic [tsqd_pkg::DSW-1:0]  dsq_q, dsq_d;
  logic [tsqd_pkg::NW-1:0]   n0_q, n0_d, n1_q, n1_d;
  logic [tsqd_pkg::NNW-1:0]  nn0_q, nn0_d, nn1_q, nn1_d;
  logic [tsqd_pkg::ACCW-1:0] p_q, p_d;
  logic [tsqd_pkg::ACCW-1:0] qd_q, qd_d;
  logic [tsqd_pkg::QB-1:0]   q_q, q_d;
  logic [tsqd_pkg::MW-1:0]   mx_q, mx_d, my_q, my_d;

  logic [tsqd_pkg::NW-1:0]   mul_a, mul_b;
  logic [tsqd_pkg::NNW-1:0]  prod;
  logic [tsqd_pkg::ACCW-1:0] dsq_ext, nn_sel, qd_sh, ds_sh, cand, rnd_lhs, rnd_rhs;
  logic [tsqd_pkg::MW-1:0]   mag;
  logic [tsqd_pkg::OW-1:0]   mx_s, my_s;

  always_comb begin
    unique case (step_q)
      3'd0:    begin mul_a = tsqd_pkg::NW'(ax_q); mul_b = tsqd_pkg::NW'(ax_q); end
      3'd1:    begin mul_a = tsqd_pkg::NW'(ay_q); mul_b = tsqd_pkg::NW'(ay_q); end
      3'd2:    begin mul_a = tsqd_pkg::NW'(t_q);  mul_b = tsqd_pkg::NW'(ay_q); end
      3'd3:    begin mul_a = tsqd_pkg::NW'(t_q);  mul_b = tsqd_pkg::NW'(ax_q); end
      3'd4:    begin mul_a = n0_q;                mul_b = n0_q; end
      default: begin mul_a = n1_q;                mul_b = n1_q; end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign dsq_ext = tsqd_pkg::ACCW'(dsq_q);
  assign nn_sel  = comp_q ? tsqd_pkg::ACCW'(nn1_q) : tsqd_pkg::ACCW'(nn0_q);
  assign qd_sh   = qd_q << ({1'b0, bit_q} + 5'd1);
  assign ds_sh   = dsq_ext << {bit_q, 1'b0};
  assign cand    = p_q + qd_sh + ds_sh;
  assign rnd_lhs = (p_q << 2) + (qd_q << 2) + dsq_ext;
  assign rnd_rhs = nn_sel << 2;
  assign mag     = (rnd_lhs <= rnd_rhs) ? tsqd_pkg::MW'(q_q) + 1'b1 : tsqd_pkg::MW'(q_q);

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    bit_d    = bit_q;
    comp_d   = comp_q;
    ax_d     = ax_q;
    ay_d     = ay_q;
    dy_pos_d = dy_pos_q;
    dx_neg_d = dx_neg_q;
    t_d      = t_q;
    dsq_d    = dsq_q;
    n0_d     = n0_q;
    n1_d     = n1_q;
    nn0_d    = nn0_q;
    nn1_d    = nn1_q;
    p_d      = p_q;
    qd_d     = qd_q;
    q_d      = q_q;
    mx_d     = mx_q;
    my_d     = my_q;
    unique case (state_q)
      R_IDLE: begin
        if (start_i) begin
          ax_d     = dx_i[tsqd_pkg::DW-1] ? tsqd_pkg::DW'(-dx_i) : dx_i;
          ay_d     = dy_i[tsqd_pkg::DW-1] ? tsqd_pkg::DW'(-dy_i) : dy_i;
          dy_pos_d = (dy_i > 0);
          dx_neg_d = dx_i[tsqd_pkg::DW-1];
          t_d      = thick_i;
          step_d   = 3'd0;
          state_d  = R_MUL;
        end
      end
      R_MUL: begin
        unique case (step_q)
          3'd0:    dsq_d = tsqd_pkg::DSW'(prod);
          3'd1:    dsq_d = dsq_q + tsqd_pkg::DSW'(prod);
          3'd2:    n0_d  = tsqd_pkg::NW'(prod);
          3'd3:    n1_d  = tsqd_pkg::NW'(prod);
          3'd4:    nn0_d = prod;
          default: nn1_d = prod;
        endcase
        step_d = step_q + 3'd1;
        if (step_q == 3'd5) begin
          comp_d = 1'b0;
          bit_d  = 4'(tsqd_pkg::QB - 1);
          p_d    = '0;
          qd_d   = '0;
          q_d    = '0;
          if (dsq_q == '0) begin
            mx_d    = '0;
            my_d    = tsqd_pkg::MW'(t_q);
            state_d = R_DONE;
          end else begin
            state_d = R_BIT;
          end
        end
      end
      R_BIT: begin
        if (cand <= nn_sel) begin
          p_d        = cand;
          qd_d       = qd_q + (dsq_ext << bit_q);
          q_d[bit_q] = 1'b1;
        end
        bit_d = bit_q - 4'd1;
        if (bit_q == 4'd0) begin
          state_d = R_RND;
        end
      end
      R_RND: begin
        if (comp_q) begin
          my_d    = mag;
          state_d = R_DONE;
        end else begin
          mx_d    = mag;
          comp_d  = 1'b1;
          bit_d   = 4'(tsqd_pkg::QB - 1);
          p_d     = '0;
          qd_d    = '0;
          q_d     = '0;
          state_d = R_BIT;
        end
      end
      R_DONE: begin
        state_d = R_IDLE;
      end
      default: begin
        state_d = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      step_q  <= '0;
      bit_q   <= '0;
      comp_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      bit_q   <= bit_d;
      comp_q  <= comp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q     <= ax_d;
    ay_q     <= ay_d;
    dy_pos_q <= dy_pos_d;
    dx_neg_q <= dx_neg_d;
    t_q      <= t_d;
    dsq_q    <= dsq_d;
    n0_q     <= n0_d;
    n1_q     <= n1_d;
    nn0_q    <= nn0_d;
    nn1_q    <= nn1_d;
    p_q      <= p_d;
    qd_q     <= qd_d;
    q_q      <= q_d;
    mx_q     <= mx_d;
    my_q     <= my_d;
  end

  assign mx_s      = {1'b0, mx_q};
  assign my_s      = {1'b0, my_q};
  assign done_o    = (state_q == R_DONE);
  assign perp_o.ox = dy_pos_q ? -$signed(mx_s) : $signed(mx_s);
  assign perp_o.oy = dx_neg_q ? -$signed(my_s) : $signed(my_s);

endmodule

/* sv/thick_segment_quad_drag_top.sv */
// Top level of the thick segment quad block: endpoint store, drag logic and output register.
// Depends on tsqd_pkg and tsqd_perp.
//
// Usage: each input item either sets one endpoint or drags the segment by the mouse
// position plus a grab offset, captured when drag_start is set. A drag that would put
// either endpoint outside the area is undone and flagged in m_axis_tuser.
// Every input item gives exactly one result item: the four corners of the segment
// widened by the thickness register on both sides, clamped to the coordinate range.
// Configuration writes go through the cfg channel, which is always ready; they are
// meant to happen while no item is in flight.
// From input accept to m_axis_tvalid an item passes the update and start states, a
// six-step multiply phase, two root loops in tsqd_perp and the hand-off states R_DONE
// and S_OUT. The input is not ready during that time, so a new item is taken only
// after the result of the last one has been registered.
// Zero-length segments skip the root loops.
// If the receiver stalls, the result is held in the output register; the block
// still takes the next item but cannot finish it until the register is free.
// Reset clears both endpoints and the grab offset and loads the register defaults.
module thick_segment_quad_drag_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // pos_x, pos_y
  input  logic [2:0]   s_axis_tuser,   // kind, endpoint_sel, drag_start
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y
  output logic [0:0]   m_axis_tuser,   // move_rejected
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_addr_i,
  input  logic [14:0]  cfg_data_i
);

  localparam int CW = tsqd_pkg::CW;
  localparam int DW = tsqd_pkg::DW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_DIFF = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;

  logic [tsqd_pkg::TW-1:0] thick_q;
  logic [tsqd_pkg::AW-1:0] area_w_q, area_h_q;

  logic signed [CW-1:0] end_x_q [2];
  logic signed [CW-1:0] end_y_q [2];
  logic signed [DW-1:0] grab_x_q, grab_y_q;

  logic                 kind_q, sel_q, start_q, rej_q;
  logic signed [CW-1:0] px_q, py_q;

  logic                 out_valid_q;
  logic [127:0]         out_data_q;
  logic                 out_rej_q;

  logic signed [DW-1:0]   gx, gy, dx, dy;
  logic signed [DW:0]     n0x, n0y;
  logic signed [DW+1:0]   n1x, n1y;
  logic                   in0, in1;
  logic                   perp_done, perp_start;
  tsqd_pkg::perp_t        perp;
  logic signed [CW:0]     ca_x, ca_y, cb_x, cb_y, cc_x, cc_y, cd_x, cd_y;
  logic signed [CW:0]     ox_e, oy_e;

  function automatic logic is_inside(input logic signed [DW+1:0] x,
                                     input logic signed [DW+1:0] y,
                                     input logic [tsqd_pkg::AW-1:0] w,
                                     input logic [tsqd_pkg::AW-1:0] h);
    return !x[DW+1] && !y[DW+1] &&
           (x <= $signed({4'b0, w})) && (y <= $signed({4'b0, h})) &&
           (x <= $signed((DW+2)'(2 ** (CW - 1) - 1))) &&
           (y <= $signed((DW+2)'(2 ** (CW - 1) - 1)));
  endfunction

  assign dx = $signed({end_x_q[1][CW-1], end_x_q[1]}) - $signed({end_x_q[0][CW-1], end_x_q[0]});
  assign dy = $signed({end_y_q[1][CW-1], end_y_q[1]}) - $signed({end_y_q[0][CW-1], end_y_q[0]});

  assign gx = start_q ? $signed({end_x_q[0][CW-1], end_x_q[0]}) - $signed({px_q[CW-1], px_q})
                      : grab_x_q;
  assign gy = start_q ? $signed({end_y_q[0][CW-1], end_y_q[0]}) - $signed({py_q[CW-1], py_q})
                      : grab_y_q;
  assign n0x = $signed({{2{px_q[CW-1]}}, px_q}) + $signed({gx[DW-1], gx});
  assign n0y = $signed({{2{py_q[CW-1]}}, py_q}) + $signed({gy[DW-1], gy});
  assign n1x = $signed({n0x[DW], n0x}) + $signed({{2{dx[DW-1]}}, dx});
  assign n1y = $signed({n0y[DW], n0y}) + $signed({{2{dy[DW-1]}}, dy});
  assign in0 = is_inside($signed({n0x[DW], n0x}), $signed({n0y[DW], n0y}), area_w_q, area_h_q);
  assign in1 = is_inside(n1x, n1y, area_w_q, area_h_q);

  assign perp_start = (state_q == S_DIFF);

  tsqd_perp u_perp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (perp_start),
    .dx_i    (dx),
    .dy_i    (dy),
    .thick_i (thick_q),
    .done_o  (perp_done),
    .perp_o  (perp)
  );

  assign ox_e = (CW+1)'(perp.ox);
  assign oy_e = (CW+1)'(perp.oy);
  assign ca_x = $signed({end_x_q[0][CW-1], end_x_q[0]}) + ox_e;
  assign ca_y = $signed({end_y_q[0][CW-1], end_y_q[0]}) + oy_e;
  assign cb_x = $signed({end_x_q[1][CW-1], end_x_q[1]}) + ox_e;
  assign cb_y = $signed({end_y_q[1][CW-1], end_y_q[1]}) + oy_e;
  assign cc_x = $signed({end_x_q[1][CW-1], end_x_q[1]}) - ox_e;
  assign cc_y = $signed({end_y_q[1][CW-1], end_y_q[1]}) - oy_e;
  assign cd_x = $signed({end_x_q[0][CW-1], end_x_q[0]}) - ox_e;
  assign cd_y = $signed({end_y_q[0][CW-1], end_y_q[0]}) - oy_e;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (s_axis_tvalid) state_d = S_UPD;
      S_UPD:   state_d = S_DIFF;
      S_DIFF:  state_d = S_WAIT;
      S_WAIT:  if (perp_done) state_d = S_OUT;
      S_OUT:   if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      thick_q     <= tsqd_pkg::THICK_RST;
      area_w_q    <= tsqd_pkg::AREA_W_RST;
      area_h_q    <= tsqd_pkg::AREA_H_RST;
      end_x_q[0]  <= '0;
      end_x_q[1]  <= '0;
      end_y_q[0]  <= '0;
      end_y_q[1]  <= '0;
      grab_x_q    <= '0;
      grab_y_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_addr_i)
          tsqd_pkg::CFG_THICK:  thick_q  <= cfg_data_i[tsqd_pkg::TW-1:0];
          tsqd_pkg::CFG_AREA_W: area_w_q <= cfg_data_i;
          tsqd_pkg::CFG_AREA_H: area_h_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_UPD) begin
        if (kind_q == tsqd_pkg::KIND_SET) begin
          end_x_q[sel_q] <= px_q;
          end_y_q[sel_q] <= py_q;
        end else begin
          grab_x_q <= gx;
          grab_y_q <= gy;
          if (in0 && in1) begin
            end_x_q[0] <= n0x[CW-1:0];
            end_y_q[0] <= n0y[CW-1:0];
            end_x_q[1] <= n1x[CW-1:0];
            end_y_q[1] <= n1y[CW-1:0];
          end
        end
      end
      if (state_q == S_OUT && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid) begin
      kind_q  <= s_axis_tuser[0];
      sel_q   <= s_axis_tuser[1];
      start_q <= s_axis_tuser[2];
      px_q    <= s_axis_tdata[15:0];
      py_q    <= s_axis_tdata[31:16];
    end
    if (state_q == S_UPD) begin
      rej_q <= (kind_q == tsqd_pkg::KIND_DRAG) && !(in0 && in1);
    end
    if (state_q == S_OUT && (!out_valid_q || m_axis_tready)) begin
      out_rej_q  <= rej_q;
      out_data_q <= {tsqd_pkg::sat_coord(cd_y), tsqd_pkg::sat_coord(cd_x),
                     tsqd_pkg::sat_coord(cc_y), tsqd_pkg::sat_coord(cc_x),
                     tsqd_pkg::sat_coord(cb_y), tsqd_pkg::sat_coord(cb_x),
                     tsqd_pkg::sat_coord(ca_y), tsqd_pkg::sat_coord(ca_x)};
    end
  end

  assign s_axis_tready   = (state_q == S_IDLE);
  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_rej_q;
  assign cfg_ready_o     = 1'b1;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    perp_done |-> state_q == S_WAIT)
    else $error("perpendicular unit finished outside the wait state");

  a_accept_to_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> state_q == S_UPD)
    else $error("accepted item did not enter the update step");

  a_drag_stays_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && kind_q == tsqd_pkg::KIND_DRAG && in0 && in1)
      |=> !end_x_q[0][CW-1] && !end_y_q[0][CW-1] && !end_x_q[1][CW-1] && !end_y_q[1][CW-1])
    else $error("accepted drag left an endpoint at a negative coordinate");

endmodule
